// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TWT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TWT_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TWT_ASSERT(lbl, clk, rstn, prop, msg)
`define TWT_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// ===== design/twt_pkg.sv =====
// ----------------------------------------------------------------------------
// Torus wrap test package
// Grid dimensions, derived widths and the flood step result type.
// ----------------------------------------------------------------------------
package twt_pkg;

    localparam int MAX_SIDE   = 5;
    localparam int GRID_W     = 2 * MAX_SIDE;
    localparam int CELLS      = MAX_SIDE * GRID_W;
    localparam int OCC_W      = MAX_SIDE * MAX_SIDE;
    localparam int SIDE_W     = 3;
    localparam int ROW_W      = $clog2(MAX_SIDE);
    localparam int COL_W      = $clog2(GRID_W);
    localparam int CELL_W     = $clog2(CELLS);
    localparam int POS_W      = $clog2(OCC_W);
    localparam int MIN_SIDE   = 2;
    localparam int SIDE_RESET = 5;

    typedef struct packed {
        logic [CELLS-1:0] reach;
        logic             changed;
    } flood_res_t;

endpackage

// ===== design/twt_grid_map.sv =====
// ----------------------------------------------------------------------------
// Doubled grid mapping
// Spreads the occupancy word over a grid of 2L columns, the right half
// repeating the left; sites outside the L by 2L window read as empty.
// ----------------------------------------------------------------------------
module twt_grid_map
    import twt_pkg::*;
(
    input  logic [OCC_W-1:0]  occupancy,
    input  logic [SIDE_W-1:0] side,
    output logic [CELLS-1:0]  grid
);

    always_comb begin
        logic [ROW_W-1:0] row_v;
        logic [COL_W-1:0] col_v;
        logic [COL_W-1:0] cc;
        logic [POS_W-1:0] pos;
        grid = '0;
        for (int r = 0; r < MAX_SIDE; r++) begin
            for (int c = 0; c < GRID_W; c++) begin
                row_v = ROW_W'(r);
                col_v = COL_W'(c);
                if (col_v >= COL_W'(side)) begin
                    cc = col_v - COL_W'(side);
                end else begin
                    cc = col_v;
                end
                pos = POS_W'(POS_W'(row_v) * POS_W'(side)) + POS_W'(cc);
                if ((row_v < ROW_W'(side)) && (col_v < COL_W'({side, 1'b0}))) begin
                    grid[r*GRID_W + c] = occupancy[pos];
                end
            end
        end
    end

endmodule

// ===== design/twt_flood_unit.sv =====
// ----------------------------------------------------------------------------
// Flood step unit
// Grows the reached set by one neighbour step over the occupied sites.
// Rows wrap at the side length in use; columns do not wrap.
// ----------------------------------------------------------------------------
module twt_flood_unit
    import twt_pkg::*;
(
    input  logic [CELLS-1:0]  grid,
    input  logic [CELLS-1:0]  reach,
    input  logic [SIDE_W-1:0] side,
    output flood_res_t        res
);

    logic [GRID_W-1:0] rows [MAX_SIDE];
    logic [GRID_W-1:0] last_row;
    logic [CELLS-1:0]  grown;
    logic [ROW_W-1:0]  bottom;

    assign bottom = ROW_W'(side - SIDE_W'(1));

    for (genvar r = 0; r < MAX_SIDE; r++) begin : g_split
        assign rows[r] = reach[r*GRID_W +: GRID_W];
    end

    always_comb begin
        last_row = '0;
        for (int k = 0; k < MAX_SIDE; k++) begin
            if (ROW_W'(k) == bottom) begin
                last_row = rows[k];
            end
        end
    end

    for (genvar r = 0; r < MAX_SIDE; r++) begin : g_row
        logic [GRID_W-1:0] up_row;
        logic [GRID_W-1:0] down_row;
        logic [GRID_W-1:0] nb;

        if (r == 0) begin : g_top
            assign up_row = last_row;
        end else begin : g_mid_up
            assign up_row = rows[r-1];
        end

        if (r == MAX_SIDE - 1) begin : g_bot
            assign down_row = rows[0];
        end else begin : g_mid_down
            assign down_row = (ROW_W'(r) == bottom) ? rows[0] : rows[r+1];
        end

        assign nb = rows[r] | up_row | down_row | (rows[r] << 1) | (rows[r] >> 1);
        assign grown[r*GRID_W +: GRID_W] = grid[r*GRID_W +: GRID_W] & nb;
    end

    assign res.reach   = grown;
    assign res.changed = (grown != reach);

endmodule

// ===== design/torus_horizontal_wrap_test.sv =====
// ----------------------------------------------------------------------------
// Torus horizontal wrap test
// Decides whether an occupied cluster winds horizontally round an L by L
// torus of sites.
//
// One occupancy word is taken on the s_ channel when s_valid and s_ready are
// both high; s_ready is high only while the block is idle. The result flag
// leaves on the m_ channel through an output register, so a stalled receiver
// holds the flag without blocking the next transfer in. cfg_wr_en writes the
// side length, to be done only while idle; values below 2 act as 2 and values
// above the built maximum act as the maximum.
// For each row in turn the reached set is seeded at column 0 and grown one
// neighbour step per cycle by the shared flood unit until it stops changing;
// the search ends at the first row whose copy at column L is reached, or
// after the last row. Each row passes through the seed state and then the
// flood state, and the flag leaves through the emit state.
// Synchronous reset returns the sequencer to idle, drops m_valid and sets the
// side length to 5.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module torus_horizontal_wrap_test
    import twt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [SIDE_W-1:0] cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OCC_W-1:0]  s_occupancy,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_wraps_flag
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SEED  = 2'd1;
    localparam logic [1:0] S_FLOOD = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [SIDE_W-1:0] side_length_reg;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CELLS-1:0]  grid_reg, grid_next;
    logic [CELLS-1:0]  reach_reg, reach_next;
    logic              flag_reg, flag_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_flag_reg, m_flag_next;

    logic [SIDE_W-1:0] side_use;
    logic [ROW_W-1:0]  last_row;
    logic [CELL_W-1:0] seed_idx;
    logic [CELL_W-1:0] hit_idx;
    logic [CELLS-1:0]  map_grid;
    flood_res_t        flood;

    always_comb begin
        if (side_length_reg < SIDE_W'(MIN_SIDE)) begin
            side_use = SIDE_W'(MIN_SIDE);
        end else if (side_length_reg > SIDE_W'(MAX_SIDE)) begin
            side_use = SIDE_W'(MAX_SIDE);
        end else begin
            side_use = side_length_reg;
        end
    end

    assign last_row = ROW_W'(side_use - SIDE_W'(1));
    assign seed_idx = CELL_W'(CELL_W'(row_reg) * CELL_W'(GRID_W));
    assign hit_idx  = seed_idx + CELL_W'(side_use);

    twt_grid_map u_grid_map (
        .occupancy (s_occupancy),
        .side      (side_use),
        .grid      (map_grid)
    );

    twt_flood_unit u_flood_unit (
        .grid  (grid_reg),
        .reach (reach_reg),
        .side  (side_use),
        .res   (flood)
    );

    always_comb begin
        state_next   = state_reg;
        row_next     = row_reg;
        grid_next    = grid_reg;
        reach_next   = reach_reg;
        flag_next    = flag_reg;
        m_valid_next = m_valid_reg;
        m_flag_next  = m_flag_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    grid_next  = map_grid;
                    row_next   = '0;
                    state_next = S_SEED;
                end
            end
            S_SEED: begin
                reach_next = grid_reg & (CELLS'(1) << seed_idx);
                state_next = S_FLOOD;
            end
            S_FLOOD: begin
                if (flood.changed) begin
                    reach_next = flood.reach;
                end else if (reach_reg[hit_idx]) begin
                    flag_next  = 1'b1;
                    state_next = S_EMIT;
                end else if (row_reg == last_row) begin
                    flag_next  = 1'b0;
                    state_next = S_EMIT;
                end else begin
                    row_next   = row_reg + ROW_W'(1);
                    state_next = S_SEED;
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_flag_next  = flag_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            row_reg         <= '0;
            m_valid_reg     <= 1'b0;
            side_length_reg <= SIDE_W'(SIDE_RESET);
        end else begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                side_length_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        grid_reg   <= grid_next;
        reach_reg  <= reach_next;
        flag_reg   <= flag_next;
        m_flag_reg <= m_flag_next;
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_wraps_flag = m_flag_reg;

    `TWT_ASSERT_NORST(a_reset_idle, aclk, !aresetn |=> (state_reg == S_IDLE) && !m_valid_reg, "reset did not return to idle")
    `TWT_ASSERT(a_accept_seeds, aclk, aresetn, (s_valid && s_ready) |=> (state_reg == S_SEED), "accepted transfer did not start seeding")
    `TWT_ASSERT(a_reach_occupied, aclk, aresetn, (state_reg == S_FLOOD) |-> ((reach_reg & ~grid_reg) == '0), "reached set holds an empty site")
    `TWT_ASSERT(a_result_from_emit, aclk, aresetn, $rose(m_valid_reg) |-> ($past(state_reg) == S_EMIT), "result shown outside emit")
    `TWT_ASSERT(a_emit_value, aclk, aresetn, ((state_reg == S_EMIT) && !m_valid_reg) |=> (m_valid_reg && (m_flag_reg == $past(flag_reg))), "emitted flag does not match search result")

endmodule

// ===== tb/tb_torus_horizontal_wrap_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Torus horizontal wrap test bench
// Drives occupancy words through the valid/ready input channel, with the
// sender working in random bursts and the receiver stalling on its own
// pattern. A directed table covering the grid extremes and the side length
// clamping is followed by random grids of varied density over random side
// settings. Every flag is compared with its expected value, either fixed in
// the directed table or given by a flood fill predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_torus_horizontal_wrap_test;
    import twt_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 100;
    localparam int DIRECTED_ROWS  = 25;

    typedef enum logic [1:0] {
        WANT_CLEAR,
        WANT_SET,
        WANT_MODEL
    } flag_want_e;

    typedef struct packed {
        logic              set_side;
        logic [SIDE_W-1:0] side;
        logic [OCC_W-1:0]  occ;
        flag_want_e        want;
    } directed_row_t;

    logic              aclk         = 1'b0;
    logic              aresetn      = 1'b0;
    logic              cfg_wr_en    = 1'b0;
    logic [SIDE_W-1:0] cfg_wr_data  = '0;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic [OCC_W-1:0]  s_occupancy  = '0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic              m_wraps_flag;

    logic [SIDE_W-1:0] side_setting = SIDE_W'(SIDE_RESET);
    bit                pending_flags [$];
    int                burst_left;
    int                mismatches;
    int                items_sent;
    int                results_seen;
    int                flags_set;
    int                quiet_cycles;
    logic [9:0]        ready_phase;
    logic [7:0]        sides_written;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{1'b0, 3'd5, 25'h0000000, WANT_CLEAR},
        '{1'b0, 3'd5, 25'h1FFFFFF, WANT_SET},
        '{1'b0, 3'd5, 25'h000001F, WANT_SET},
        '{1'b0, 3'd5, 25'h0108421, WANT_CLEAR},
        '{1'b0, 3'd5, 25'h0000001, WANT_CLEAR},
        '{1'b0, 3'd5, 25'h1F00000, WANT_SET},
        '{1'b0, 3'd5, 25'h1083105, WANT_MODEL},
        '{1'b0, 3'd5, 25'h0AAAAAA, WANT_MODEL},
        '{1'b1, 3'd0, 25'h0000003, WANT_SET},
        '{1'b0, 3'd0, 25'h1FFFFF0, WANT_CLEAR},
        '{1'b0, 3'd0, 25'h0000005, WANT_CLEAR},
        '{1'b0, 3'd0, 25'h0000009, WANT_MODEL},
        '{1'b1, 3'd1, 25'h000000C, WANT_SET},
        '{1'b0, 3'd1, 25'h0000006, WANT_MODEL},
        '{1'b1, 3'd7, 25'h1FFFFFF, WANT_SET},
        '{1'b0, 3'd7, 25'h000001F, WANT_SET},
        '{1'b0, 3'd7, 25'h0000000, WANT_CLEAR},
        '{1'b1, 3'd6, 25'h1F00000, WANT_SET},
        '{1'b1, 3'd3, 25'h1FFFE00, WANT_CLEAR},
        '{1'b0, 3'd3, 25'h0000007, WANT_SET},
        '{1'b0, 3'd3, 25'h00001C0, WANT_SET},
        '{1'b0, 3'd3, 25'h00000A6, WANT_MODEL},
        '{1'b1, 3'd4, 25'h000F000, WANT_SET},
        '{1'b0, 3'd4, 25'h0008421, WANT_MODEL},
        '{1'b1, 3'd2, 25'h0000009, WANT_MODEL}
    };

    torus_horizontal_wrap_test dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_occupancy  (s_occupancy),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_wraps_flag (m_wraps_flag)
    );

    always #10 aclk = ~aclk;

    // The grid is doubled to 2L columns; rows wrap, columns do not. The
    // reached set is grown from each occupied column 0 site until it settles.
    function automatic bit cluster_winds(input logic [OCC_W-1:0] occ,
                                         input logic [SIDE_W-1:0] side_code);
        int n;
        int w;
        int row;
        int r;
        int c;
        int up;
        int dn;
        bit grown;
        bit site  [MAX_SIDE][GRID_W];
        bit reach [MAX_SIDE][GRID_W];
        n = (side_code < MIN_SIDE) ? MIN_SIDE :
            (side_code > MAX_SIDE) ? MAX_SIDE : int'(side_code);
        w = 2 * n;
        for (r = 0; r < n; r++) begin
            for (c = 0; c < w; c++) begin
                site[r][c] = occ[r * n + ((c >= n) ? c - n : c)];
            end
        end
        for (row = 0; row < n; row++) begin
            if (!site[row][0]) continue;
            for (r = 0; r < n; r++) begin
                for (c = 0; c < w; c++) begin
                    reach[r][c] = 1'b0;
                end
            end
            reach[row][0] = 1'b1;
            do begin
                grown = 1'b0;
                for (r = 0; r < n; r++) begin
                    up = (r == 0) ? n - 1 : r - 1;
                    dn = (r == n - 1) ? 0 : r + 1;
                    for (c = 0; c < w; c++) begin
                        if (site[r][c] && !reach[r][c] &&
                            (reach[up][c] || reach[dn][c] ||
                             (c > 0 && reach[r][c-1]) ||
                             (c + 1 < w && reach[r][c+1]))) begin
                            reach[r][c] = 1'b1;
                            grown = 1'b1;
                        end
                    end
                end
            end while (grown);
            if (reach[row][n]) return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic offer_occupancy(input logic [OCC_W-1:0] occ, input flag_want_e want);
        int gap;
        bit want_flag;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_valid     <= 1'b1;
        s_occupancy <= occ;
        do @(posedge aclk); while (!s_ready);
        case (want)
            WANT_CLEAR: want_flag = 1'b0;
            WANT_SET:   want_flag = 1'b1;
            default:    want_flag = cluster_winds(occ, side_setting);
        endcase
        pending_flags = {pending_flags, want_flag};
        burst_left--;
        items_sent++;
    endtask

    // The side length may only change once every outstanding flag is back.
    task automatic apply_side(input logic [SIDE_W-1:0] side);
        s_valid <= 1'b0;
        while (pending_flags.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= side;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        side_setting  = side;
        sides_written[side] = 1'b1;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            ready_phase <= '0;
            m_ready     <= 1'b0;
        end else begin
            ready_phase <= ready_phase + 1'b1;
            case (ready_phase[9:8])
                2'd0: m_ready <= 1'b1;
                2'd1: m_ready <= ($urandom_range(0, 3) != 0);
                2'd2: m_ready <= (ready_phase[2:0] < 3'd3);
                default: m_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    always @(posedge aclk) begin : check_results
        bit expected_flag;
        if (aresetn && m_valid && m_ready) begin
            if (pending_flags.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer, wraps_flag %b", m_wraps_flag));
            end else begin
                expected_flag = pending_flags.pop_front();
                results_seen++;
                if (m_wraps_flag) flags_set++;
                if (m_wraps_flag !== expected_flag) begin
                    report_mismatch($sformatf("wraps_flag %b, expected %b",
                                              m_wraps_flag, expected_flag));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int i;
        int phase;
        int k;
        int b;
        int density;
        logic [SIDE_W-1:0] side;
        logic [OCC_W-1:0]  occ;
        sides_written = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < DIRECTED_ROWS; i++) begin
            if (directed_rows[i].set_side) apply_side(directed_rows[i].side);
            offer_occupancy(directed_rows[i].occ, directed_rows[i].want);
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            side = (phase == 0) ? 3'd7 : (phase == 1) ? 3'd0 : SIDE_W'($urandom_range(0, 7));
            apply_side(side);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 7) == 0) begin
                    occ = OCC_W'($urandom);
                end else begin
                    density = $urandom_range(35, 95);
                    for (b = 0; b < OCC_W; b++) begin
                        occ[b] = ($urandom_range(0, 99) < density);
                    end
                end
                offer_occupancy(occ, WANT_MODEL);
            end
        end

        s_valid <= 1'b0;
        while (pending_flags.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (pending_flags.size() != 0) begin
            report_mismatch($sformatf("%0d flags never arrived", pending_flags.size()));
        end

        $display("Sent %0d occupancy words under side settings %b (bit per value).",
                 items_sent, sides_written);
        $display("Checked %0d flags, %0d of them showing a horizontal wrap.",
                 results_seen, flags_set);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
